/* rtl/rtu_frm_pkg.sv */
// Shared types, status codes and CRC helper for the RTU response frame checker.
`default_nettype none
package rtu_frm_pkg;

   localparam logic [7:0]  MIN_FRAME_LEN = 8'd5;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;
   localparam logic [7:0]  DATA_BYTES_WR = 8'd4;
   localparam logic [7:0]  FUNC_WR_COIL  = 8'd5;
   localparam logic [7:0]  FUNC_WR_REG   = 8'd6;

   localparam logic [7:0] RST_SLAVE    = 8'd1;
   localparam logic [7:0] RST_FUNCTION = 8'd3;
   localparam logic [7:0] RST_LENGTH   = 8'd8;

   typedef enum logic [1:0] {
      REG_SLAVE    = 2'd0,
      REG_FUNCTION = 2'd1,
      REG_LENGTH   = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TIMEOUT   = 3'd1,
      ST_EXCEPTION = 3'd2,
      ST_CRC       = 3'd3,
      ST_SLAVE     = 3'd4,
      ST_FUNCTION  = 3'd5
   } status_type;

   typedef enum logic {
      ACT_BYTE    = 1'b0,
      ACT_TIMEOUT = 1'b1
   } action_type;

   typedef struct packed {
      logic       action;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] exception_code;
      logic [7:0] resp_slave;
      logic [7:0] resp_function;
      logic [7:0] data_bytes;
      logic [7:0] frame_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0] expected_slave;
      logic [7:0] expected_function;
      logic [7:0] expected_length;
   } cfg_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* rtl/rtu_frm_core.sv */
// Frame state, CRC update and status decision for one request per cycle while fire is high.
`default_nettype none
module rtu_frm_core
   import rtu_frm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type item,
   input  wire cfg_type cfg,
   output logic         produce,
   output rsp_type      result
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  addr_ff, addr_in;
   logic [7:0]  func_ff, func_in;
   logic [7:0]  third_ff, third_in;
   logic        done_ff, done_in;

   logic [7:0]  len;
   logic        exc_frame;
   logic        complete;
   logic [7:0]  rep_addr, rep_func, rep_third, rep_count;

   assign len = (cfg.expected_length < MIN_FRAME_LEN) ? MIN_FRAME_LEN : cfg.expected_length;

   always_comb begin
      crc_in   = crc_ff;
      count_in = count_ff;
      addr_in  = addr_ff;
      func_in  = func_ff;
      third_in = third_ff;
      done_in  = done_ff;
      produce  = 1'b0;
      exc_frame = 1'b0;
      complete  = 1'b0;
      rep_addr  = addr_ff;
      rep_func  = func_ff;
      rep_third = third_ff;
      rep_count = count_ff;
      result.status         = ST_TIMEOUT;
      result.exception_code = 8'h00;
      if (item.action == ACT_TIMEOUT) begin
         produce  = !done_ff;
         crc_in   = CRC_INIT;
         count_in = 8'd0;
         addr_in  = 8'd0;
         func_in  = 8'd0;
         third_in = 8'd0;
         done_in  = 1'b0;
      end else if (!done_ff) begin
         if (count_ff == 8'd0) addr_in = item.rx_byte;
         if (count_ff == 8'd1) func_in = item.rx_byte;
         if (count_ff == 8'd2) third_in = item.rx_byte;
         crc_in   = crc_byte(crc_ff, item.rx_byte);
         count_in = count_ff + 8'd1;
         exc_frame = func_in[7] && (count_in >= 8'd2);
         complete  = (exc_frame && count_in == MIN_FRAME_LEN) || (count_in >= len);
         done_in   = complete;
         produce   = complete;
         rep_addr  = addr_in;
         rep_func  = func_in;
         rep_third = third_in;
         rep_count = count_in;
         if (exc_frame) begin
            result.status         = ST_EXCEPTION;
            result.exception_code = third_in;
         end else if (crc_in != 16'h0000) begin
            result.status = ST_CRC;
         end else if (addr_in != cfg.expected_slave) begin
            result.status = ST_SLAVE;
         end else if (func_in != cfg.expected_function) begin
            result.status = ST_FUNCTION;
         end else begin
            result.status = ST_OK;
         end
      end
      result.resp_slave    = rep_addr;
      result.resp_function = rep_func;
      result.data_bytes    = (rep_func == FUNC_WR_COIL || rep_func == FUNC_WR_REG) ?
                             DATA_BYTES_WR : rep_third;
      result.frame_length  = rep_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= CRC_INIT;
         count_ff <= 8'd0;
         addr_ff  <= 8'd0;
         func_ff  <= 8'd0;
         third_ff <= 8'd0;
         done_ff  <= 1'b0;
      end else if (fire) begin
         crc_ff   <= crc_in;
         count_ff <= count_in;
         addr_ff  <= addr_in;
         func_ff  <= func_in;
         third_ff <= third_in;
         done_ff  <= done_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/rtu_response_frame_checker_unit.sv */
// An accepted request passes the input register and then the result register, which drives rsp_valid.
// Throughput: one request per cycle without rsp_stall; byte-wide CRC and compares in one stage.
// A request that ends no frame gives no response.
// Reset (synchronous): frame state restarts, CRC to 0xFFFF, registers to 1, 3, 8.
// No clearing pass: requests are taken from the first cycle after reset.
// Top level of the RTU response frame checker: handshake stages and registers.
`default_nettype none
module rtu_response_frame_checker_unit
   import rtu_frm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic [1:0] csr_index,
   input  wire logic [7:0] csr_data
);

   cfg_type cfg_ff;
   logic    in_valid_ff;
   req_type in_ff;
   logic    out_valid_ff;
   rsp_type out_ff;
   logic    proc_fire;
   logic    produce;
   rsp_type result;

   assign csr_ready = 1'b1;
   assign proc_fire = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !proc_fire;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.expected_slave    <= RST_SLAVE;
         cfg_ff.expected_function <= RST_FUNCTION;
         cfg_ff.expected_length   <= RST_LENGTH;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SLAVE:    cfg_ff.expected_slave    <= csr_data;
            REG_FUNCTION: cfg_ff.expected_function <= csr_data;
            REG_LENGTH:   cfg_ff.expected_length   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (!req_stall && req_valid) begin
         in_ff <= req_data;
      end
   end

   rtu_frm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (proc_fire),
      .item    (in_ff),
      .cfg     (cfg_ff),
      .produce (produce),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (proc_fire) begin
         out_valid_ff <= produce;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
      if (proc_fire && produce) begin
         out_ff <= result;
      end
   end

`ifndef NO_ASSERTIONS
   a_drain_free: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_valid_ff) |-> !req_stall)
      else $error("stall raised with an empty result register");

   a_exc_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_EXCEPTION) |-> (rsp_data.exception_code == 8'h00))
      else $error("exception code set outside an exception response");

   a_capture: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> in_valid_ff)
      else $error("accepted request not held in the input register");
`endif

endmodule
`default_nettype wire
